>>> rtl/jsds_pkg.sv
package jsds_pkg;

   localparam logic [7:0] MARKER_PREFIX = 8'hFF;
   localparam logic [7:0] MARKER_SOI    = 8'hD8;
   localparam logic [7:0] MARKER_EOI    = 8'hD9;
   localparam logic [7:0] MARKER_SOS    = 8'hDA;
   localparam logic [7:0] MARKER_TEM    = 8'h01;
   localparam logic [7:0] MARKER_RST0   = 8'hD0;
   localparam logic [7:0] MARKER_RST7   = 8'hD7;
   localparam logic [7:0] MARKER_SOF0   = 8'hC0;
   localparam logic [7:0] MARKER_SOF15  = 8'hCF;
   localparam logic [7:0] MARKER_DHT    = 8'hC4;
   localparam logic [7:0] MARKER_JPG    = 8'hC8;
   localparam logic [7:0] MARKER_DAC    = 8'hCC;

   // Shortest frame header that still holds both dimensions.
   localparam logic [15:0] FRAME_MIN_LENGTH = 16'd7;

   typedef enum logic [2:0] {
      STATUS_FOUND      = 3'd0,
      STATUS_BAD_START  = 3'd1,
      STATUS_MALFORMED  = 3'd2,
      STATUS_SHORT_HDR  = 3'd3,
      STATUS_ZERO_DIM   = 3'd4
   } scan_status_type;

   typedef enum logic [4:0] {
      PHASE_SOI0 = 5'b00001,
      PHASE_SOI1 = 5'b00010,
      PHASE_SCAN = 5'b00100,
      PHASE_FILL = 5'b01000,
      PHASE_SEG  = 5'b10000
   } parse_phase_type;

   typedef struct packed {
      parse_phase_type phase;
      logic [15:0]     seg_offset;
      logic [15:0]     seg_length;
      logic            frame_hdr;
      logic [15:0]     height;
      logic [15:0]     width;
      logic [1:0]      seen;
      logic            given;
   } scan_state_type;

   typedef struct packed {
      logic            valid;
      scan_status_type status;
      logic [15:0]     width;
      logic [15:0]     height;
   } scan_result_type;

   localparam scan_state_type SCAN_STATE_RESET = '{
      phase:      PHASE_SOI0,
      seg_offset: 16'd0,
      seg_length: 16'd0,
      frame_hdr:  1'b0,
      height:     16'd0,
      width:      16'd0,
      seen:       2'd0,
      given:      1'b0
   };

   localparam logic [1:0] SEEN_MAX = 2'd3;

endpackage

>>> rtl/jsds_if.sv
interface jsds_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       last_byte;

   modport source (output valid, output byte_value, output last_byte, input ready);
   modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

interface jsds_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] image_width;
   logic [15:0] image_height;
   logic [2:0]  scan_status;

   modport source (output valid, output image_width, output image_height,
                   output scan_status, input ready);
   modport sink (input valid, input image_width, input image_height,
                 input scan_status, output ready);
endinterface

>>> rtl/jsds_step.sv
module jsds_step
   import jsds_pkg::*;
(
   input  scan_state_type  cur_state,
   input  logic [7:0]      byte_value,
   input  logic            last_byte,
   output scan_state_type  next_state,
   output scan_result_type result
);

   scan_state_type  adv_state;
   logic            adv_done;
   scan_status_type adv_status;
   logic [16:0]     next_offset;
   logic [15:0]     length_now;
   logic            frame_marker;
   logic            standalone;

   assign next_offset  = {1'b0, cur_state.seg_offset} + 17'd1;
   assign length_now   = (cur_state.seg_offset == 16'd1) ?
                         {cur_state.seg_length[15:8], byte_value} : cur_state.seg_length;
   assign frame_marker = (byte_value >= MARKER_SOF0) && (byte_value <= MARKER_SOF15) &&
                         (byte_value != MARKER_DHT) && (byte_value != MARKER_JPG) &&
                         (byte_value != MARKER_DAC);
   assign standalone   = (byte_value == MARKER_TEM) ||
                         ((byte_value >= MARKER_RST0) && (byte_value <= MARKER_RST7));

   // One step of the marker walk.
   always_comb begin
      adv_state  = cur_state;
      adv_done   = 1'b0;
      adv_status = STATUS_MALFORMED;
      unique case (cur_state.phase)
         PHASE_SOI0: begin
            if (byte_value != MARKER_PREFIX) begin
               adv_done   = 1'b1;
               adv_status = STATUS_BAD_START;
            end else begin
               adv_state.phase = PHASE_SOI1;
            end
         end
         PHASE_SOI1: begin
            if (byte_value != MARKER_SOI) begin
               adv_done   = 1'b1;
               adv_status = STATUS_BAD_START;
            end else begin
               adv_state.phase = PHASE_SCAN;
            end
         end
         PHASE_SCAN: begin
            if (byte_value == MARKER_PREFIX) begin
               adv_state.phase = PHASE_FILL;
            end
         end
         PHASE_FILL: begin
            priority if (byte_value == MARKER_PREFIX) begin
               adv_state.phase = PHASE_FILL;
            end else if ((byte_value == MARKER_EOI) || (byte_value == MARKER_SOS)) begin
               adv_done   = 1'b1;
               adv_status = STATUS_MALFORMED;
            end else if (standalone) begin
               adv_state.phase = PHASE_SCAN;
            end else begin
               adv_state.frame_hdr  = frame_marker;
               adv_state.seg_offset = 16'd0;
               adv_state.seg_length = 16'd0;
               adv_state.phase      = PHASE_SEG;
            end
         end
         PHASE_SEG: begin
            if (cur_state.seg_offset == 16'd0) begin
               adv_state.seg_length = {byte_value, 8'd0};
               adv_state.seg_offset = 16'd1;
            end else begin
               adv_state.seg_length = length_now;
               if (cur_state.frame_hdr) begin
                  unique case (cur_state.seg_offset)
                     16'd3:   adv_state.height = {byte_value, 8'd0};
                     16'd4:   adv_state.height = {cur_state.height[15:8], byte_value};
                     16'd5:   adv_state.width  = {byte_value, 8'd0};
                     16'd6:   adv_state.width  = {cur_state.width[15:8], byte_value};
                     default: ;
                  endcase
               end
               priority if ((cur_state.seg_offset == 16'd1) && (length_now < 16'd2)) begin
                  adv_done   = 1'b1;
                  adv_status = STATUS_MALFORMED;
               end else if (next_offset >= {1'b0, length_now}) begin
                  // The whole segment has arrived, so a frame header can decide now.
                  if (cur_state.frame_hdr) begin
                     adv_done = 1'b1;
                     priority if (length_now < FRAME_MIN_LENGTH) begin
                        adv_status = STATUS_SHORT_HDR;
                     end else if ((adv_state.width != 16'd0) &&
                                  (adv_state.height != 16'd0)) begin
                        adv_status = STATUS_FOUND;
                     end else begin
                        adv_status = STATUS_ZERO_DIM;
                     end
                  end else begin
                     adv_state.phase = PHASE_SCAN;
                  end
               end else begin
                  adv_state.seg_offset = next_offset[15:0];
               end
            end
         end
         default: adv_state.phase = PHASE_SCAN;
      endcase
   end

   always_comb begin
      next_state    = cur_state;
      result.valid  = 1'b0;
      result.status = STATUS_MALFORMED;
      if (!cur_state.given) begin
         next_state = adv_state;
         priority if (last_byte && (cur_state.seen < SEEN_MAX)) begin
            result.valid  = 1'b1;
            result.status = STATUS_BAD_START;
         end else if (adv_done) begin
            result.valid  = 1'b1;
            result.status = adv_status;
         end else if (last_byte) begin
            result.valid  = 1'b1;
            result.status = STATUS_MALFORMED;
         end else begin
            result.valid  = 1'b0;
         end
      end
      result.width  = (result.status == STATUS_FOUND) ? adv_state.width : 16'd0;
      result.height = (result.status == STATUS_FOUND) ? adv_state.height : 16'd0;
      next_state.seen  = (cur_state.seen == SEEN_MAX) ? SEEN_MAX : cur_state.seen + 2'd1;
      next_state.given = cur_state.given | result.valid;
      if (last_byte) begin
         next_state = SCAN_STATE_RESET;
      end
   end

endmodule

>>> rtl/jpeg_sof_dimension_scanner.sv
// A deciding request goes into the input register, then the parse step writes its result
// into the result register.
// Throughput: one byte per cycle while the output is not stalled; the parse state is updated once per byte.
// A result waiting in the output register holds the staged byte, so requests stall too.
// Reset (synchronous, active high) clears the parse state and both valid flags.
module jpeg_sof_dimension_scanner
   import jsds_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   jsds_req_if.sink       req_bus,
   jsds_rsp_if.source     rsp_bus
);

   logic            stage_valid_ff, stage_valid_in;
   logic [7:0]      stage_byte_ff;
   logic            stage_last_ff;
   scan_state_type  state_ff, state_in;
   scan_result_type step_result;
   logic            rsp_valid_ff, rsp_valid_in;
   scan_status_type rsp_status_ff;
   logic [15:0]     rsp_width_ff;
   logic [15:0]     rsp_height_ff;
   logic            req_fire;
   logic            step_go;

   // The staged byte may move on when the output register is empty or being drained.
   assign step_go        = stage_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready  = !stage_valid_ff || step_go;
   assign req_fire       = req_bus.valid && req_bus.ready;
   assign stage_valid_in = req_fire | (stage_valid_ff & ~step_go);
   assign rsp_valid_in   = step_go ? step_result.valid : (rsp_valid_ff && !rsp_bus.ready);

   jsds_step u_step (
      .cur_state  (state_ff),
      .byte_value (stage_byte_ff),
      .last_byte  (stage_last_ff),
      .next_state (state_in),
      .result     (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         state_ff       <= SCAN_STATE_RESET;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (step_go) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_byte_ff <= req_bus.byte_value;
         stage_last_ff <= req_bus.last_byte;
      end
      if (step_go && step_result.valid) begin
         rsp_status_ff <= step_result.status;
         rsp_width_ff  <= step_result.width;
         rsp_height_ff <= step_result.height;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.scan_status  = rsp_status_ff;
   assign rsp_bus.image_width  = rsp_width_ff;
   assign rsp_bus.image_height = rsp_height_ff;

endmodule

>>> rtl/jsds_checker.sv
module jsds_checker
   import jsds_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [15:0] rsp_width,
   input logic [15:0] rsp_height
);

   // A stalled response keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
                                  $stable(rsp_width) && $stable(rsp_height))
      else $error("stalled response changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_FOUND) |-> (rsp_width == 16'd0) &&
                                                    (rsp_height == 16'd0))
      else $error("dimensions reported without a found status");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FOUND) |-> (rsp_width != 16'd0) &&
                                                    (rsp_height != 16'd0))
      else $error("found status with a zero dimension");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind jpeg_sof_dimension_scanner jsds_checker u_jsds_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_status (rsp_bus.scan_status),
   .rsp_width  (rsp_bus.image_width),
   .rsp_height (rsp_bus.image_height)
);
